// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the block bitmap allocator
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int IDX_W      = 12;
   localparam int CNT_OUT_W  = 13;
   localparam int RSV_W      = 12;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_DATA_W-1:0] NUM_BLOCKS_RESET = 13'd4096;

   // commands carried by a request beat
   typedef enum logic [1:0] {
      CMD_FORMAT,
      CMD_ALLOC,
      CMD_FREE,
      CMD_MARK
   } cmd_type;

   // result codes
   typedef enum logic [1:0] {
      STAT_DONE,
      STAT_NO_FREE,
      STAT_RANGE,
      STAT_ALREADY
   } status_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_NUM_BLOCKS,
      CSR_RESERVED_LAST
   } csr_index_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [IDX_W-1:0]  req_index;
   } req_data_type;

   typedef struct packed {
      status_type            status;
      logic [IDX_W-1:0]      block_index;
      logic [CNT_OUT_W-1:0]  free_count;
   } rsp_data_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic format;
      logic scan;
      logic finish;
      logic emit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_format;
      logic early;
      logic scan_done;
      logic rsp_busy;
   } ctl_stat_type;

endpackage

// File: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// command sequencer of the block bitmap allocator
// ----------------------------------------------------------------------------
module bba_ctrl
   import bba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctl_stat_type stat,
   output ctl_cmd_type  ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_format) begin
               ctl.format = 1'b1;
               state_in   = ST_RESPOND;
            end else if (stat.early) begin
               ctl.finish = 1'b1;
               state_in   = ST_RESPOND;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            if (stat.scan_done) begin
               ctl.finish = 1'b1;
               state_in   = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!stat.rsp_busy) begin
               ctl.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/bba_dpath.sv
// ----------------------------------------------------------------------------
// bba_dpath
// bitmap storage, word scan, free count and result register
// ----------------------------------------------------------------------------
module bba_dpath
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS    = 4096,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           ctl,
   output ctl_stat_type          stat,
   input  req_data_type          req_data,
   input  logic [CSR_DATA_W-1:0] num_blocks,
   input  logic [RSV_W-1:0]      reserved_last,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsp_data_type          rsp_data
);

   localparam int W      = MAP_WORD_BITS;
   localparam int WORDS  = (MAX_BLOCKS + W - 1) / W;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW     = $clog2(WORDS + 1);
   localparam int BIT_W  = $clog2(W);
   localparam int BW_RAW = $clog2(MAX_BLOCKS + 2 * W + 1);
   localparam int BW     = (BW_RAW > 14) ? BW_RAW : 14;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

   // ones in the bits below k, k taken as signed
   function automatic logic [W-1:0] therm(input logic signed [BW:0] k);
      logic [W-1:0] m;
      for (int b = 0; b < W; b++) begin
         m[b] = (k > $signed((BW+1)'(b)));
      end
      return m;
   endfunction

   // latched request
   cmd_type           cmd_ff;
   logic [IDX_W-1:0]  idx_ff;

   // scan pointers
   logic [PW-1:0]     ptr_ff, ptr_in;
   logic [BW-1:0]     base_ff, base_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_addr_ff;
   logic [BW-1:0]     rd_base_ff;

   // map state
   logic [WORDS-1:0]  valid_ff, valid_in;
   logic              fmt_done_ff, fmt_done_in;
   logic [RSV_W-1:0]  fmt_rsv_ff;
   logic [CNT_W-1:0]  free_ff, free_in;

   // result
   status_type        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_index_ff, res_index_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff;

   logic [W-1:0]      ram_q;
   logic [W-1:0]      word_eff;
   logic [W-1:0]      elig;
   logic [W-1:0]      oh_a, oh_t, new_word;
   logic [BIT_W-1:0]  pos_a, pos_t;
   logic [BW-1:0]     n_ext, n_eff, idx_ext, rsv_ext, rsv1, fmt_used, off;
   logic [CNT_W-1:0]  fmt_free;
   logic signed [BW:0] rsv_k, lim_k;
   logic              is_alloc, is_free, hit_a, last_a, hit_t, cur, same;
   logic              issue_ok, commit, early;

   // effective block count, limited to capacity
   assign n_ext   = BW'(num_blocks);
   assign n_eff   = (n_ext > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : n_ext;
   assign idx_ext = BW'(idx_ff);
   assign rsv_ext = BW'(reserved_last);
   assign rsv1    = rsv_ext + BW'(1);

   // format count: blocks below the limit minus reserved ones below it
   assign fmt_used = (rsv1 < n_eff) ? rsv1 : n_eff;
   assign fmt_free = CNT_W'(n_eff - fmt_used);

   assign is_alloc = (cmd_ff == CMD_ALLOC);
   assign is_free  = (cmd_ff == CMD_FREE);

   assign early = is_alloc ? (free_ff == '0)
                           : ((idx_ext <= rsv_ext) || (idx_ext >= n_eff));

   assign issue_ok = (ptr_ff < PW'(WORDS));

   // word never written since format reads as its reserved pattern
   assign rsv_k = $signed({1'b0, BW'(fmt_rsv_ff)}) - $signed({1'b0, rd_base_ff})
                + $signed((BW+1)'(1));
   always_comb begin
      if (valid_ff[rd_addr_ff]) begin
         word_eff = ram_q;
      end else if (fmt_done_ff) begin
         word_eff = therm(rsv_k);
      end else begin
         word_eff = '0;
      end
   end

   // allocate: lowest clear bit below the block count
   assign lim_k  = $signed({1'b0, n_eff}) - $signed({1'b0, rd_base_ff});
   assign elig   = ~word_eff & therm(lim_k);
   assign hit_a  = |elig;
   assign last_a = ((rd_base_ff + BW'(W)) >= n_eff);

   always_comb begin
      pos_a = '0;
      for (int b = W - 1; b >= 0; b--) begin
         if (elig[b]) begin
            pos_a = BIT_W'(b);
         end
      end
   end

   // free and mark-used: word holding the requested index
   assign off   = idx_ext - rd_base_ff;
   assign hit_t = (off < BW'(W));
   assign pos_t = off[BIT_W-1:0];
   assign cur   = word_eff[pos_t];
   assign same  = is_free ? !cur : cur;

   assign oh_a = W'(1) << pos_a;
   assign oh_t = W'(1) << pos_t;

   always_comb begin
      case (cmd_ff)
         CMD_ALLOC: new_word = word_eff | oh_a;
         CMD_FREE:  new_word = word_eff & ~oh_t;
         CMD_MARK:  new_word = word_eff | oh_t;
         default:   new_word = word_eff;
      endcase
   end

   assign commit = ctl.finish && rd_vld_ff && (is_alloc ? hit_a : !same);

   assign stat.is_format = (cmd_ff == CMD_FORMAT);
   assign stat.early     = early;
   assign stat.scan_done = rd_vld_ff && (is_alloc ? (hit_a || last_a) : hit_t);
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;

   bba_ram #(
      .WIDTH (W),
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (rd_addr_ff),
      .wr_data (new_word),
      .rd_en   (ctl.scan && issue_ok),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      ptr_in        = ptr_ff;
      base_in       = base_ff;
      rd_vld_in     = 1'b0;
      valid_in      = valid_ff;
      fmt_done_in   = fmt_done_ff;
      free_in       = free_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;

      if (ctl.start) begin
         ptr_in  = '0;
         base_in = '0;
      end else if (ctl.scan) begin
         ptr_in    = ptr_ff + PW'(1);
         base_in   = base_ff + BW'(W);
         rd_vld_in = issue_ok;
      end

      if (ctl.format) begin
         valid_in      = '0;
         fmt_done_in   = 1'b1;
         free_in       = fmt_free;
         res_status_in = STAT_DONE;
         res_index_in  = '0;
      end

      if (ctl.finish) begin
         if (!rd_vld_ff) begin
            res_status_in = is_alloc ? STAT_NO_FREE : STAT_RANGE;
            res_index_in  = is_alloc ? '0 : idx_ff;
         end else if (is_alloc) begin
            res_status_in = hit_a ? STAT_DONE : STAT_NO_FREE;
            res_index_in  = hit_a ? IDX_W'(rd_base_ff + BW'(pos_a)) : '0;
         end else begin
            res_status_in = same ? STAT_ALREADY : STAT_DONE;
            res_index_in  = idx_ff;
         end
      end

      if (commit) begin
         valid_in[rd_addr_ff] = 1'b1;
         if (is_free) begin
            if (free_ff < CNT_W'(MAX_BLOCKS)) begin
               free_in = free_ff + CNT_W'(1);
            end
         end else if (free_ff != '0) begin
            free_in = free_ff - CNT_W'(1);
         end
      end
   end

   assign rsp_valid_in = ctl.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         fmt_done_ff  <= 1'b0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         fmt_done_ff  <= fmt_done_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cmd_ff <= req_data.cmd;
         idx_ff <= req_data.req_index;
      end
      if (ctl.format) begin
         fmt_rsv_ff <= reserved_last;
      end
      if (ctl.scan) begin
         rd_addr_ff <= ptr_ff[AW-1:0];
         rd_base_ff <= base_ff;
      end
      if (ctl.emit) begin
         rsp_data_ff.status      <= res_status_ff;
         rsp_data_ff.block_index <= res_index_ff;
         rsp_data_ff.free_count  <= CNT_OUT_W'(free_ff);
      end
      ptr_ff        <= ptr_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// first-fit used/free bitmap of disk blocks with a free block count
// ----------------------------------------------------------------------------
// One request beat runs one command: format, allocate, free or mark-used, and
// gives exactly one response beat with a status, a block index and the free
// count after the command. The map lives in a ram of MAP_WORD_BITS-wide words
// with one valid flag per word; format clears the flags and a word not
// written since then reads as its reserved pattern, so there is no clearing
// pass after reset. Format, an allocate with a zero free count and an
// out-of-range free or mark-used go from the check state straight to the
// response state. Allocate, free and mark-used otherwise walk the map one
// word per cycle from word 0 through the pipelined ram read, up to the word
// that holds the target bit or, for an allocate with no clear bit, the last
// word below the block count. One command is in flight at a time; a new
// request beat is taken the cycle after the response is loaded, even while
// that response still waits on rsp_stall. Format must run before the first
// allocate: until then the free count is zero and allocate reports no free
// block. Configuration must be written only while no command is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS    = 4096,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,

   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,

   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,

   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CSR_DATA_W-1:0] num_blocks_ff;
   logic [RSV_W-1:0]      reserved_last_ff;
   ctl_cmd_type           ctl;
   ctl_stat_type          stat;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff    <= NUM_BLOCKS_RESET;
         reserved_last_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_BLOCKS:    num_blocks_ff    <= csr_wdata;
            CSR_RESERVED_LAST: reserved_last_ff <= csr_wdata[RSV_W-1:0];
            default: begin
               num_blocks_ff <= num_blocks_ff;
            end
         endcase
      end
   end

   // sequencer
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // map, scan and result register
   bba_dpath #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_data      (req_data),
      .num_blocks    (num_blocks_ff),
      .reserved_last (reserved_last_ff),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

`ifndef SYNTHESIS
   // one command at a time: an accepted beat closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a command is in flight");

   // a failed allocate carries block index zero
   a_no_free_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_NO_FREE) |-> (rsp_data.block_index == '0))
      else $error("no-free response with nonzero block index");

   // free count never exceeds capacity
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.free_count) <= 32'(MAX_BLOCKS)))
      else $error("free count above capacity");

   // a range status names a reserved index or one at or past the block count
   a_range_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_RANGE) |->
         (32'(rsp_data.block_index) <= 32'(reserved_last_ff)) ||
         (32'(rsp_data.block_index) >= 32'(num_blocks_ff)))
      else $error("range status on an index inside the block range");
`endif

endmodule
